/* hw/rtl/fwdf_pkg.sv */
// Shared types and constants for the fixed-width decimal formatter.
package fwdf_pkg;

    localparam int MAX_WIDTH   = 16;
    localparam int VALUE_W     = 32;
    localparam int NUM_DIGITS  = 10;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int WIDTH_W     = 5;
    localparam int PLACE_W     = $clog2(MAX_WIDTH);
    localparam int CNT_W       = $clog2(VALUE_W);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NONE  = 8'h00;

    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_NEG = 2'd1;
    localparam logic [1:0] STATUS_OVF = 2'd2;

    localparam logic REG_FIELD_WIDTH = 1'b0;
    localparam logic REG_SIGN_MODE   = 1'b1;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 5'd11;
    localparam logic [WIDTH_W-1:0] WIDTH_LIMIT = 5'(MAX_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_CHECK,
        ST_EMIT,
        ST_FAIL
    } fwdf_state_t;

    typedef struct packed {
        logic load;
    } dab_ctrl_t;

endpackage

/* hw/rtl/fwdf_dabble.sv */
// Bit-serial binary to BCD converter.
module fwdf_dabble (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fwdf_pkg::dab_ctrl_t            ctrl,
    input  logic [fwdf_pkg::VALUE_W-1:0]   mag,
    output logic                           run,
    output logic [fwdf_pkg::BCD_W-1:0]     bcd
);
    import fwdf_pkg::*;

    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   adj;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (ctrl.load)
        begin
            mag_next = mag;
            bcd_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            bcd_next = {adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
            mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_W - 1))
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            run_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign run = run_reg;
    assign bcd = bcd_reg;

endmodule

/* hw/rtl/fixed_width_decimal_formatter.sv */
// Top level: control sequencer, configuration registers and character output.
// An accepted value, unless it is negative with sign mode off, is converted by a
// bit-serial binary to BCD unit that takes one magnitude bit per cycle, followed by a
// range check; the characters then leave one per cycle, sign first when sign mode is
// on. busy stays high from acceptance until the final word, or the single error word
// on a width overflow or a negative value with sign mode off, has been produced. Each
// character word is shown for one cycle with strobe high, starting the cycle after it
// is produced, and cannot be held off.
module fixed_width_decimal_formatter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [31:0]             value,
    input  logic                           cfg_write,
    input  logic                           cfg_addr,
    input  logic [fwdf_pkg::WIDTH_W-1:0]   cfg_data,
    output logic                           strobe,
    output logic [7:0]                     character,
    output logic                           last,
    output logic [1:0]                     status
);
    import fwdf_pkg::*;

    fwdf_state_t         state_reg, state_next;
    logic [WIDTH_W-1:0]  width_reg;
    logic                sign_mode_reg;
    logic                neg_reg, neg_next;
    logic [1:0]          code_reg, code_next;
    logic [PLACE_W-1:0]  place_reg, place_next;
    logic                sign_pend_reg, sign_pend_next;
    logic                strobe_reg, strobe_next;
    logic [7:0]          character_reg, character_next;
    logic                last_reg, last_next;
    logic [1:0]          status_reg, status_next;

    dab_ctrl_t           dctl;
    logic                dab_run;
    logic [BCD_W-1:0]    bcd;
    logic [VALUE_W-1:0]  mag;
    logic                accept;
    logic                in_neg;
    logic [WIDTH_W-1:0]  fw;
    logic [WIDTH_W-1:0]  nfw;
    logic                ovf;
    logic [3:0]          digit;

    assign accept = start && (state_reg == ST_IDLE);
    assign in_neg = value[31];
    assign mag    = in_neg ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);

    assign fw = (width_reg > WIDTH_LIMIT) ? WIDTH_LIMIT : width_reg;

    always_comb
    begin
        if (sign_mode_reg)
            nfw = (fw == '0) ? '0 : fw - 1'b1;
        else
            nfw = fw;
    end

    always_comb
    begin
        ovf = (nfw == '0);
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if ((bcd[4*i +: 4] != 4'd0) && (WIDTH_W'(i) >= nfw))
                ovf = 1'b1;
        end
    end

    always_comb
    begin
        digit = 4'd0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (place_reg == PLACE_W'(i))
                digit = bcd[4*i +: 4];
        end
    end

    fwdf_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dctl),
        .mag   (mag),
        .run   (dab_run),
        .bcd   (bcd)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (in_neg && !sign_mode_reg) ? ST_FAIL : ST_CONV;
            end
            ST_CONV:
            begin
                if (!dab_run)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = ovf ? ST_FAIL : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!sign_pend_reg && (place_reg == '0))
                    state_next = ST_IDLE;
            end
            ST_FAIL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dctl.load      = 1'b0;
        neg_next       = neg_reg;
        code_next      = code_reg;
        place_next     = place_reg;
        sign_pend_next = sign_pend_reg;
        strobe_next    = 1'b0;
        character_next = character_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next  = in_neg;
                    code_next = STATUS_NEG;
                    dctl.load = !(in_neg && !sign_mode_reg);
                end
            end
            ST_CONV:
            begin
            end
            ST_CHECK:
            begin
                code_next      = STATUS_OVF;
                place_next     = PLACE_W'(nfw - 1'b1);
                sign_pend_next = sign_mode_reg;
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                status_next = STATUS_OK;
                if (sign_pend_reg)
                begin
                    character_next = neg_reg ? CHAR_MINUS : CHAR_PLUS;
                    last_next      = 1'b0;
                    sign_pend_next = 1'b0;
                end
                else
                begin
                    character_next = CHAR_ZERO + {4'd0, digit};
                    last_next      = (place_reg == '0);
                    place_next     = place_reg - 1'b1;
                end
            end
            ST_FAIL:
            begin
                strobe_next    = 1'b1;
                character_next = CHAR_NONE;
                last_next      = 1'b1;
                status_next    = code_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= WIDTH_RESET;
            sign_mode_reg <= 1'b1;
            strobe_reg    <= 1'b0;
            sign_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            strobe_reg    <= strobe_next;
            sign_pend_reg <= sign_pend_next;
            if (cfg_write && (cfg_addr == REG_FIELD_WIDTH))
                width_reg <= cfg_data;
            if (cfg_write && (cfg_addr == REG_SIGN_MODE))
                sign_mode_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg       <= neg_next;
        code_reg      <= code_next;
        place_reg     <= place_next;
        character_reg <= character_next;
        last_reg      <= last_next;
        status_reg    <= status_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign character = character_reg;
    assign last      = last_reg;
    assign status    = status_reg;

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status != STATUS_OK)) |-> (last && (character == CHAR_NONE)))
        else $error("error word not marked last");

    a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && last))
        else $error("busy dropped without a final word");

    a_quiet_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !strobe)
        else $error("word shown right after accept");

    a_conv_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !dab_run)
        else $error("converter still running during output");

endmodule

/* verif/tb_fixed_width_decimal_formatter.sv */
// Self-checking testbench for the fixed-width decimal formatter with its own field predictor.
module tb_fixed_width_decimal_formatter;
    timeunit 1ns;
    timeprecision 1ps;

    import fwdf_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       lst;
        logic [1:0] st;
    } char_word_t;

    typedef struct {
        logic [4:0]  width;
        logic        sign;
        logic [31:0] num;
        bit          typed;
        logic [7:0]  ch;
        logic [1:0]  st;
    } format_case_t;

    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 44;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] value = '0;
    logic        cfg_write = 1'b0;
    logic        cfg_addr = REG_FIELD_WIDTH;
    logic [4:0]  cfg_data = '0;
    logic        strobe;
    logic [7:0]  character;
    logic        last;
    logic [1:0]  status;

    logic [4:0]  width_reg = WIDTH_RESET;
    logic        sign_on = 1'b1;
    char_word_t  expected_chars [$];
    char_word_t  next_word;
    int          mismatches = 0;

    format_case_t format_cases [23] = '{
        '{5'd11, 1'b1, 32'd0,          1'b0, CHAR_NONE,      STATUS_OK},
        '{5'd11, 1'b1, 32'h7FFF_FFFF,  1'b0, CHAR_NONE,      STATUS_OK},
        '{5'd11, 1'b1, 32'h8000_0000,  1'b0, CHAR_NONE,      STATUS_OK},
        '{5'd11, 1'b1, 32'hFFFF_FFFF,  1'b0, CHAR_NONE,      STATUS_OK},
        '{5'd10, 1'b1, 32'h7FFF_FFFF,  1'b1, CHAR_NONE,      STATUS_OVF},
        '{5'd16, 1'b1, 32'h8000_0000,  1'b0, CHAR_NONE,      STATUS_OK},
        '{5'd16, 1'b0, 32'h7FFF_FFFF,  1'b0, CHAR_NONE,      STATUS_OK},
        '{5'd16, 1'b0, 32'hFFFF_FFFF,  1'b1, CHAR_NONE,      STATUS_NEG},
        '{5'd16, 1'b0, 32'h8000_0000,  1'b1, CHAR_NONE,      STATUS_NEG},
        '{5'd1,  1'b0, 32'd0,          1'b1, CHAR_ZERO,      STATUS_OK},
        '{5'd1,  1'b0, 32'd9,          1'b1, CHAR_ZERO + 8'd9, STATUS_OK},
        '{5'd1,  1'b0, 32'd10,         1'b1, CHAR_NONE,      STATUS_OVF},
        '{5'd1,  1'b1, 32'd0,          1'b1, CHAR_NONE,      STATUS_OVF},
        '{5'd1,  1'b1, 32'hFFFF_FFFB,  1'b1, CHAR_NONE,      STATUS_OVF},
        '{5'd0,  1'b1, 32'd0,          1'b1, CHAR_NONE,      STATUS_OVF},
        '{5'd0,  1'b0, 32'd7,          1'b1, CHAR_NONE,      STATUS_OVF},
        '{5'd0,  1'b0, 32'hFFFF_FFF9,  1'b1, CHAR_NONE,      STATUS_NEG},
        '{5'd31, 1'b0, 32'd123,        1'b0, CHAR_NONE,      STATUS_OK},
        '{5'd17, 1'b1, 32'hFFFF_FF9D,  1'b0, CHAR_NONE,      STATUS_OK},
        '{5'd2,  1'b1, 32'd9,          1'b0, CHAR_NONE,      STATUS_OK},
        '{5'd2,  1'b1, 32'hFFFF_FFF7,  1'b0, CHAR_NONE,      STATUS_OK},
        '{5'd10, 1'b0, 32'h7FFF_FFFF,  1'b0, CHAR_NONE,      STATUS_OK},
        '{5'd9,  1'b0, 32'd1000000000, 1'b1, CHAR_NONE,      STATUS_OVF}
    };

    fixed_width_decimal_formatter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .character (character),
        .last      (last),
        .status    (status)
    );

    always #5 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("tb_fixed_width_decimal_formatter: errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 50)
            $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int unsigned usable_digits();
        int unsigned fw;
        fw = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        if (sign_on)
            return (fw > 0) ? fw - 1 : 0;
        return fw;
    endfunction

    function automatic void format_field(input logic [31:0] num);
        logic        neg;
        logic [31:0] rest;
        logic [3:0]  dig [10];
        int unsigned fw;
        int unsigned nfw;
        int unsigned nd;
        int unsigned place;
        logic [7:0]  ch;
        neg = num[31];
        rest = neg ? (~num + 32'd1) : num;
        if (neg && !sign_on)
        begin
            expected_chars.push_back('{CHAR_NONE, 1'b1, STATUS_NEG});
            return;
        end
        fw = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        nd = 0;
        do
        begin
            dig[nd] = 4'(rest % 10);
            nd++;
            rest = rest / 10;
        end
        while (rest != 0 && nd < 10);
        nfw = usable_digits();
        if (fw == 0 || nd > nfw)
        begin
            expected_chars.push_back('{CHAR_NONE, 1'b1, STATUS_OVF});
            return;
        end
        if (sign_on)
            expected_chars.push_back('{neg ? CHAR_MINUS : CHAR_PLUS, 1'b0, STATUS_OK});
        for (int unsigned k = 0; k < nfw; k++)
        begin
            place = nfw - 1 - k;
            ch = CHAR_ZERO + ((place < nd) ? 8'(dig[place]) : 8'd0);
            expected_chars.push_back('{ch, k == nfw - 1, STATUS_OK});
        end
    endfunction

    function automatic logic [31:0] random_value();
        int unsigned nfw;
        int unsigned d;
        longint      lo;
        longint      hi;
        logic [31:0] mag;
        logic        neg;
        nfw = usable_digits();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 7))
                    0: return 32'd0;
                    1: return 32'd1;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h7FFF_FFFF;
                    4: return 32'h8000_0000;
                    5: return 32'd9;
                    6: return 32'hFFFF_FFF7;
                    default: return 32'd10;
                endcase
            end
            default:
            begin
                if (nfw >= 1 && $urandom_range(0, 99) < 85)
                    d = $urandom_range(1, (nfw > 10) ? 10 : nfw);
                else
                    d = $urandom_range(1, 10);
                lo = 1;
                for (int i = 1; i < d; i++)
                    lo = lo * 10;
                hi = (d == 10) ? 64'd2147483647 : lo * 10 - 1;
                if (d == 1)
                    lo = 0;
                mag = $urandom_range(int'(hi), int'(lo));
                neg = sign_on ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 9) == 0);
                return neg ? (~mag + 32'd1) : mag;
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int gap;
        gap = 0;
        if ($urandom_range(0, 9) < 3)
            gap = $urandom_range(1, 17);
        return gap;
    endfunction

    task automatic send_value(input logic [31:0] num);
        start <= 1'b1;
        value <= num;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic hold_sender(input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap)
            begin
                value <= $urandom;
                @(posedge clk);
            end
        end
    endtask

    task automatic quiesce();
        start <= 1'b0;
        while (expected_chars.size() != 0 || busy)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
    endtask

    task automatic apply_format(input logic [4:0] w, input logic s);
        logic [4:0] sign_word;
        logic       width_first;
        sign_word = {4'($urandom), s};
        width_first = $urandom_range(0, 1);
        quiesce();
        cfg_write <= 1'b1;
        for (int i = 0; i < 2; i++)
        begin
            if ((i == 0) == width_first)
            begin
                cfg_addr <= REG_FIELD_WIDTH;
                cfg_data <= w;
            end
            else
            begin
                cfg_addr <= REG_SIGN_MODE;
                cfg_data <= sign_word;
            end
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        width_reg = w;
        sign_on = s;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_chars.size() == 0)
                report_mismatch($sformatf("unexpected word char=%h last=%b status=%0d",
                                          character, last, status));
            else
            begin
                next_word = expected_chars.pop_front();
                if (character !== next_word.ch)
                    report_mismatch($sformatf("character %h, want %h",
                                              character, next_word.ch));
                if (last !== next_word.lst)
                    report_mismatch($sformatf("last %b, want %b", last, next_word.lst));
                if (status !== next_word.st)
                    report_mismatch($sformatf("status %0d, want %0d", status, next_word.st));
            end
        end
    end

    initial
    begin
        int          drain_cycles;
        logic [31:0] num;
        logic [4:0]  w;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (format_cases[i])
        begin
            if (format_cases[i].width != width_reg || format_cases[i].sign != sign_on)
                apply_format(format_cases[i].width, format_cases[i].sign);
            send_value(format_cases[i].num);
            if (format_cases[i].typed)
                expected_chars.push_back('{format_cases[i].ch, 1'b1, format_cases[i].st});
            else
                format_field(format_cases[i].num);
            hold_sender(pick_gap());
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 9))
                0: w = 5'd0;
                1: w = 5'($urandom_range(17, 31));
                2: w = 5'd16;
                3: w = 5'd1;
                default: w = 5'($urandom_range(2, 15));
            endcase
            apply_format(w, 1'($urandom_range(0, 1)));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                num = random_value();
                send_value(num);
                format_field(num);
                if (phase == RANDOM_PHASES - 1)
                    continue;
                if ($urandom_range(0, 19) == 0)
                    quiesce();
                else
                    hold_sender(pick_gap());
            end
        end

        start <= 1'b0;
        drain_cycles = 0;
        while ((expected_chars.size() != 0 || busy) && drain_cycles < 5000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (60)
            @(posedge clk);
        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", expected_chars.size()));
        if (mismatches == 0)
            $display("tb_fixed_width_decimal_formatter: clean");
        else
            $display("tb_fixed_width_decimal_formatter: errors");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/fwdf_pkg.sv
hw/rtl/fwdf_dabble.sv
hw/rtl/fixed_width_decimal_formatter.sv
verif/tb_fixed_width_decimal_formatter.sv
